>>> design/base64url_stream_decoder_core_defines.svh
// Assertion macros shared by the base64url stream decoder modules.
`ifndef BASE64URL_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64URL_STREAM_DECODER_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define B64D_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define B64D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/b64d_pkg.sv
// Package with the word types, codes and character classifier of the base64url decoder.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PAD    = 8'h3D;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    localparam logic [5:0] SEXTET_DASH  = 6'd62;
    localparam logic [5:0] SEXTET_UNDER = 6'd63;
    localparam logic [7:0] LOWER_OFFSET = 8'd71;
    localparam logic [7:0] DIGIT_OFFSET = 8'd4;

    localparam logic [1:0] KIND_SEXTET = 2'd0;
    localparam logic [1:0] KIND_PAD    = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADCHAR = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       stream_end;
        logic [1:0] status;
    } t_out_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] sextet;
        logic       last;
    } t_cls_word;

    function automatic t_cls_word classify(input t_in_word w);
        t_cls_word  r;
        logic [7:0] diff;
        diff = 8'd0;
        r.kind   = KIND_BAD;
        r.sextet = 6'd0;
        r.last   = w.last_char;
        if (w.char_in >= CHAR_UPPER_A && w.char_in <= CHAR_UPPER_Z) begin
            diff     = w.char_in - CHAR_UPPER_A;
            r.kind   = KIND_SEXTET;
            r.sextet = diff[5:0];
        end else if (w.char_in >= CHAR_LOWER_A && w.char_in <= CHAR_LOWER_Z) begin
            diff     = w.char_in - LOWER_OFFSET;
            r.kind   = KIND_SEXTET;
            r.sextet = diff[5:0];
        end else if (w.char_in >= CHAR_DIGIT_0 && w.char_in <= CHAR_DIGIT_9) begin
            diff     = w.char_in + DIGIT_OFFSET;
            r.kind   = KIND_SEXTET;
            r.sextet = diff[5:0];
        end else if (w.char_in == CHAR_DASH) begin
            r.kind   = KIND_SEXTET;
            r.sextet = SEXTET_DASH;
        end else if (w.char_in == CHAR_UNDER) begin
            r.kind   = KIND_SEXTET;
            r.sextet = SEXTET_UNDER;
        end else if (w.char_in == CHAR_PAD) begin
            r.kind   = KIND_PAD;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/b64d_front.sv
// Front end: accepts input words and classifies each character for the queue.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
    input  wire                 i_valid,
    output logic                o_ready,
    input  b64d_pkg::t_in_word  i_word,
    input  wire                 i_q_full,
    output logic                o_push,
    output b64d_pkg::t_cls_word o_cls
);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_cls   = b64d_pkg::classify(i_word);

endmodule

`default_nettype wire

>>> design/b64d_fifo.sv
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

`include "base64url_stream_decoder_core_defines.svh"

module b64d_fifo #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  b64d_pkg::t_cls_word i_din,
    output logic                o_full,
    output logic                o_valid,
    input  wire                 i_pop,
    output b64d_pkg::t_cls_word o_dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64d_pkg::t_cls_word r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_dout  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_din;
        end
    end

    `B64D_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count beyond depth")
    `B64D_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, do_push && !do_pop, r_count != '0 && r_wr == $past(n_wr), "push not recorded")

endmodule

`default_nettype wire

>>> design/b64d_back.sv
// Back end: quartet state, byte assembly, error tracking and output register.
`timescale 1ns / 1ps
`default_nettype none

`include "base64url_stream_decoder_core_defines.svh"

module b64d_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  b64d_pkg::t_cls_word i_q_word,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output b64d_pkg::t_out_word o_word
);

    logic [1:0]          r_phase, n_phase;
    logic [5:0]          r_held, n_held;
    logic [1:0]          r_err, n_err;
    logic                r_out_valid;
    b64d_pkg::t_out_word r_out, n_out;
    logic [7:0]          byte_val;
    logic                byte_ok;

    assign o_pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_err    = r_err;
        byte_val = 8'd0;
        byte_ok  = 1'b0;
        if (r_err == b64d_pkg::ST_OK && i_q_word.kind != b64d_pkg::KIND_PAD) begin
            if (i_q_word.kind == b64d_pkg::KIND_BAD) begin
                n_err = b64d_pkg::ST_BADCHAR;
            end else begin
                unique case (r_phase)
                    2'd0: begin
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        byte_val = {r_held, i_q_word.sextet[5:4]};
                        byte_ok  = 1'b1;
                        n_phase  = 2'd2;
                    end
                    2'd2: begin
                        byte_val = {r_held[3:0], i_q_word.sextet[5:2]};
                        byte_ok  = 1'b1;
                        n_phase  = 2'd3;
                    end
                    default: begin
                        byte_val = {r_held[1:0], i_q_word.sextet};
                        byte_ok  = 1'b1;
                        n_phase  = 2'd0;
                    end
                endcase
                n_held = i_q_word.sextet;
            end
        end
        if (i_q_word.last && n_err == b64d_pkg::ST_OK && n_phase == 2'd1) begin
            n_err = b64d_pkg::ST_TRUNC;
        end
        n_out.data_byte  = byte_val;
        n_out.byte_valid = byte_ok;
        n_out.stream_end = i_q_word.last;
        n_out.status     = n_err;
        if (i_q_word.last) begin
            n_phase = 2'd0;
            n_held  = 6'd0;
            n_err   = b64d_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_held      <= 6'd0;
            r_err       <= b64d_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_held      <= n_held;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    `B64D_ASSERT_IMPL(a_byte_only_ok, i_clk, i_rst_n, r_out_valid && r_out.byte_valid, r_out.status == b64d_pkg::ST_OK, "byte word carries an error status")
    `B64D_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, o_pop && i_q_word.last, r_phase == 2'd0 && r_held == 6'd0 && r_err == b64d_pkg::ST_OK, "state not cleared at stream end")

endmodule

`default_nettype wire

>>> design/base64url_stream_decoder_core.sv
// Top level of the base64url stream decoder: front end, queue and back end.
// An accepted word is written into the queue, then popped into the output register and offered.
// Throughput: one character word per cycle and one result word per cycle while the output is
// ready; a full queue or a stalled output holds the flow. Classify is combinational in front.
// Reset (synchronous, active low) empties the queue and output register and clears the
// quartet phase, held sextet and error code; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module base64url_stream_decoder_core #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  b64d_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  wire                 i_ready,
    output b64d_pkg::t_out_word o_word
);

    logic                q_full;
    logic                q_push;
    logic                q_valid;
    logic                q_pop;
    b64d_pkg::t_cls_word cls_word;
    b64d_pkg::t_cls_word q_word;

    b64d_front u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_word   (i_word),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cls    (cls_word)
    );

    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_din   (cls_word),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_dout  (q_word)
    );

    b64d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_word  (q_word),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_word    (o_word)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the base64url stream decoder core, with a decoding scoreboard.
`timescale 1ns / 1ps

module testbench;
    import b64d_pkg::*;

    class b64_decode_checker;
        bit [1:0]  quartet;
        bit [5:0]  prev_sextet;
        bit [1:0]  err_state;
        t_out_word pending_results[$];
        int        mismatches;
        int        chars_seen;
        int        streams_seen;
        int        bytes_seen;
        int        badchar_streams;
        int        trunc_streams;

        function automatic bit to_sextet(input logic [7:0] c, output logic [5:0] v);
            logic [7:0] d;
            d = 8'd0;
            v = 6'd0;
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
                d = c - CHAR_UPPER_A;
            end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
                d = c - CHAR_LOWER_A + 8'd26;
            end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
                d = c - CHAR_DIGIT_0 + 8'd52;
            end else if (c == CHAR_DASH) begin
                d = {2'b00, SEXTET_DASH};
            end else if (c == CHAR_UNDER) begin
                d = {2'b00, SEXTET_UNDER};
            end else begin
                return 1'b0;
            end
            v = d[5:0];
            return 1'b1;
        endfunction

        function void predict_char(t_in_word w);
            t_out_word  r;
            logic [5:0] v;
            r = '0;
            chars_seen++;
            if (err_state == ST_OK && w.char_in != CHAR_PAD) begin
                if (!to_sextet(w.char_in, v)) begin
                    err_state = ST_BADCHAR;
                end else begin
                    case (quartet)
                        2'd0: begin
                            quartet = 2'd1;
                        end
                        2'd1: begin
                            r.data_byte  = {prev_sextet, v[5:4]};
                            r.byte_valid = 1'b1;
                            quartet      = 2'd2;
                        end
                        2'd2: begin
                            r.data_byte  = {prev_sextet[3:0], v[5:2]};
                            r.byte_valid = 1'b1;
                            quartet      = 2'd3;
                        end
                        default: begin
                            r.data_byte  = {prev_sextet[1:0], v};
                            r.byte_valid = 1'b1;
                            quartet      = 2'd0;
                        end
                    endcase
                    prev_sextet = v;
                end
            end
            if (w.last_char && err_state == ST_OK && quartet == 2'd1) begin
                err_state = ST_TRUNC;
            end
            r.stream_end = w.last_char;
            r.status     = err_state;
            if (r.byte_valid) bytes_seen++;
            if (w.last_char) begin
                streams_seen++;
                if (err_state == ST_BADCHAR) badchar_streams++;
                if (err_state == ST_TRUNC) trunc_streams++;
                quartet     = 2'd0;
                prev_sextet = 6'd0;
                err_state   = ST_OK;
            end
            pending_results.push_back(r);
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            if (pending_results.size() == 0) begin
                report("unexpected result word", got, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.data_byte !== want.data_byte)
                    report("data_byte", got.data_byte, want.data_byte);
                if (got.byte_valid !== want.byte_valid)
                    report("byte_valid", got.byte_valid, want.byte_valid);
                if (got.stream_end !== want.stream_end)
                    report("stream_end", got.stream_end, want.stream_end);
                if (got.status !== want.status)
                    report("status", got.status, want.status);
            end
        endtask
    endclass

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_word;

    logic      in_hs;
    logic      out_hs;
    t_in_word  in_w;
    t_out_word out_w;
    int        stalled_cycles;
    int        items_sent;
    bit        tx_idle;
    bit        rx_idle;
    bit        rx_hold_req;
    bit        pressure_done;

    b64_decode_checker sb = new;

    base64url_stream_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_hs          = 1'b0;
        out_hs         = 1'b0;
        in_w           = '0;
        out_w          = '0;
        stalled_cycles = 0;
    end

    // Signals only move at the rising edge, so the falling edge sees what the next edge will.
    always @(negedge i_clk) begin
        in_hs  = i_rst_n && i_valid && o_ready;
        out_hs = i_rst_n && o_valid && i_ready;
        in_w   = i_word;
        out_w  = o_word;
    end

    always @(posedge i_clk) begin
        if (in_hs) sb.predict_char(in_w);
        if (out_hs) sb.check_word(out_w);
        if (in_hs || out_hs || !i_rst_n) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        wait (stalled_cycles >= STALL_LIMIT);
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Result side: a random hold-off per word while rx_idle is set, and one long hold-off on request.
    initial begin
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!out_hs);
        end
    end

    function automatic logic [7:0] alpha_char(int idx);
        if (idx < 26) return CHAR_UPPER_A + 8'(idx);
        if (idx < 52) return CHAR_LOWER_A + 8'(idx - 26);
        if (idx < 62) return CHAR_DIGIT_0 + 8'(idx - 52);
        if (idx == 62) return CHAR_DASH;
        return CHAR_UNDER;
    endfunction

    task send_char(input logic [7:0] c, input bit ends);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= '{char_in: c, last_char: ends};
        do @(posedge i_clk); while (!in_hs);
        items_sent++;
    endtask

    task send_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], ends && (i == s.len() - 1));
        end
    endtask

    task random_stream();
        int         len;
        int         style;
        int         bad_pos;
        logic [7:0] c;
        len     = $urandom_range(1, 12);
        style   = $urandom_range(0, 99);
        bad_pos = $urandom_range(0, len - 1);
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++) begin
            if (style < 75) begin
                c = ($urandom_range(0, 9) == 0) ? CHAR_PAD : alpha_char($urandom_range(0, 63));
            end else if (style < 90 && i != bad_pos) begin
                c = alpha_char($urandom_range(0, 63));
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            send_char(c, i == len - 1);
        end
    endtask

    task pressure_stream();
        tx_idle     = 1'b0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 24; i++) begin
            send_char(alpha_char($urandom_range(0, 63)), i == 23);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_word        = '0;
        items_sent    = 0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold_req   = 1'b0;
        pressure_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("TWFu", 1'b1);
        send_text("az09-_", 1'b1);
        send_text("Q", 1'b1);
        send_text("=", 1'b1);
        send_text("Zw==", 1'b1);
        send_char(8'h00, 1'b0);
        send_text("A", 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("AB=C", 1'b0);
        send_char(8'h40, 1'b1);
        send_text("Q=", 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!pressure_done && items_sent >= 200) begin
                pressure_stream();
                pressure_done = 1'b1;
            end else begin
                random_stream();
            end
        end
        i_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Decoded %0d characters in %0d streams into %0d bytes.",
                 sb.chars_seen, sb.streams_seen, sb.bytes_seen);
        $display("Streams ending in error: %0d with an invalid character, %0d truncated.",
                 sb.badchar_streams, sb.trunc_streams);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
